### rtl/lrsi_pkg.sv
package lrsi_pkg;

    localparam int COORD_W  = 4;
    localparam int COLOR_W  = 8;
    localparam int INDEX_W  = 8;
    localparam int ERR_W    = 7;
    localparam int ROWS_DEF = 16;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture a new line request
        logic step;   // advance to the next point
    } lrsi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fin;    // current point is the end point
    } lrsi_status_t;

endpackage

### rtl/lrsi_req_if.sv
interface lrsi_req_if
    import lrsi_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (
        output valid, x_start, y_start, x_end, y_end, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, x_start, y_start, x_end, y_end, red, green, blue,
        output ready
    );
endinterface

### rtl/lrsi_pix_if.sv
interface lrsi_pix_if
    import lrsi_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               last;

    modport source (
        output valid, led_index, out_red, out_green, out_blue, last,
        input  ready
    );

    modport sink (
        input  valid, led_index, out_red, out_green, out_blue, last,
        output ready
    );
endinterface

### rtl/line_rasterizer_serpentine_index_unit.sv
// Channel    Dir  Payload                                     Transfer
// line_req   in   x_start y_start x_end y_end red green blue  valid && ready
// pixel      out  led_index out_red out_green out_blue last   valid && ready
//
// A line of n points (n = major-axis length + 1, 1 to 16) gives one pixel per
// cycle unless pixel stalls; the Bresenham walker's stepping sets the pace.
// The next request is taken in the cycle the last pixel transfers.
// rst_n clears the controller to idle; datapath registers are loaded per line.
// A stall on pixel holds the current point; line_req waits until the walk ends.
module line_rasterizer_serpentine_index_unit
    import lrsi_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    lrsi_req_if.sink   line_req,
    lrsi_pix_if.source pixel
);

    lrsi_cmd_t    cmd;
    lrsi_status_t status;

    lrsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (line_req.valid),
        .in_ready  (line_req.ready),
        .out_valid (pixel.valid),
        .out_ready (pixel.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lrsi_datapath #(
        .ROWS (ROWS)
    ) u_datapath (
        .clk       (clk),
        .cmd       (cmd),
        .status    (status),
        .x_start   (line_req.x_start),
        .y_start   (line_req.y_start),
        .x_end     (line_req.x_end),
        .y_end     (line_req.y_end),
        .red       (line_req.red),
        .green     (line_req.green),
        .blue      (line_req.blue),
        .led_index (pixel.led_index),
        .out_red   (pixel.out_red),
        .out_green (pixel.out_green),
        .out_blue  (pixel.out_blue),
        .last      (pixel.last)
    );

endmodule

### rtl/lrsi_ctrl.sv
module lrsi_ctrl
    import lrsi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  lrsi_status_t status,
    output lrsi_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   walking;
    logic   last_done;

    assign walking   = (state_reg == ST_WALK);
    // final point of the line leaves this cycle
    assign last_done = walking && out_ready && status.fin;

    assign in_ready  = (state_reg == ST_IDLE) || last_done;
    assign out_valid = walking;
    assign cmd.load  = in_valid && in_ready;
    assign cmd.step  = walking && out_ready && !status.fin;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (last_done && !cmd.load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/lrsi_datapath.sv
module lrsi_datapath
    import lrsi_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
)
(
    input  logic               clk,
    input  lrsi_cmd_t          cmd,
    output lrsi_status_t       status,
    input  logic [COORD_W-1:0] x_start,
    input  logic [COORD_W-1:0] y_start,
    input  logic [COORD_W-1:0] x_end,
    input  logic [COORD_W-1:0] y_end,
    input  logic [COLOR_W-1:0] red,
    input  logic [COLOR_W-1:0] green,
    input  logic [COLOR_W-1:0] blue,
    output logic [INDEX_W-1:0] led_index,
    output logic [COLOR_W-1:0] out_red,
    output logic [COLOR_W-1:0] out_green,
    output logic [COLOR_W-1:0] out_blue,
    output logic               last
);

    localparam logic [INDEX_W-1:0] ROWS_W    = INDEX_W'(ROWS);
    localparam logic [INDEX_W-1:0] ROWS_M1_W = INDEX_W'(ROWS - 1);
    localparam logic [COORD_W-1:0] STEP_POS  = COORD_W'(1);
    localparam logic [COORD_W-1:0] STEP_NEG  = {COORD_W{1'b1}};

    logic [COORD_W-1:0]       cur_col_reg, cur_row_reg, end_col_reg, end_row_reg;
    logic [COORD_W-1:0]       cur_col_next, cur_row_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [COORD_W:0]         twice_dx_reg, twice_dy_reg;
    logic                     neg_x_reg, neg_y_reg, x_major_reg;
    logic [COLOR_W-1:0]       red_reg, green_reg, blue_reg;

    // setup terms from the request
    logic [COORD_W-1:0]       dx, dy;
    logic                     neg_x, neg_y, x_major;
    logic [COORD_W:0]         twice_dx, twice_dy;
    logic signed [ERR_W-1:0]  err_init;

    // walk terms
    logic                     err_ge0;
    logic [COORD_W-1:0]       col_inc, row_inc;
    logic signed [ERR_W-1:0]  err_dec, err_add;
    logic [INDEX_W-1:0]       base, off;

    assign neg_x    = (x_end < x_start);
    assign neg_y    = (y_end < y_start);
    assign dx       = neg_x ? (x_start - x_end) : (x_end - x_start);
    assign dy       = neg_y ? (y_start - y_end) : (y_end - y_start);
    assign twice_dx = {dx, 1'b0};
    assign twice_dy = {dy, 1'b0};
    assign x_major  = (twice_dx > twice_dy);   // tie goes to y
    assign err_init = x_major
                    ? ERR_W'($signed({1'b0, twice_dy}) - $signed({2'b00, dx}))
                    : ERR_W'($signed({1'b0, twice_dx}) - $signed({2'b00, dy}));

    assign err_ge0  = !err_reg[ERR_W-1];
    assign col_inc  = neg_x_reg ? STEP_NEG : STEP_POS;
    assign row_inc  = neg_y_reg ? STEP_NEG : STEP_POS;

    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (x_major_reg)
        begin
            if (err_ge0)
            begin
                cur_row_next = cur_row_reg + row_inc;
            end
            cur_col_next = cur_col_reg + col_inc;
            err_dec      = err_ge0 ? ERR_W'(twice_dx_reg) : '0;
            err_add      = ERR_W'(twice_dy_reg);
        end
        else
        begin
            if (err_ge0)
            begin
                cur_col_next = cur_col_reg + col_inc;
            end
            cur_row_next = cur_row_reg + row_inc;
            err_dec      = err_ge0 ? ERR_W'(twice_dy_reg) : '0;
            err_add      = ERR_W'(twice_dx_reg);
        end
        err_next = err_reg - err_dec + err_add;
    end

    // the major axis reaches its end within 16 points, so no point count is kept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_col_reg  <= x_start;
            cur_row_reg  <= y_start;
            end_col_reg  <= x_end;
            end_row_reg  <= y_end;
            err_reg      <= err_init;
            twice_dx_reg <= twice_dx;
            twice_dy_reg <= twice_dy;
            neg_x_reg    <= neg_x;
            neg_y_reg    <= neg_y;
            x_major_reg  <= x_major;
            red_reg      <= red;
            green_reg    <= green;
            blue_reg     <= blue;
        end
        else if (cmd.step)
        begin
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            err_reg      <= err_next;
        end
    end

    assign status.fin = x_major_reg ? (cur_col_reg == end_col_reg)
                                    : (cur_row_reg == end_row_reg);

    // serpentine wiring: odd columns run bottom to top
    assign base = {{(INDEX_W-COORD_W){1'b0}}, cur_col_reg} * ROWS_W;
    assign off  = cur_col_reg[0]
                ? (ROWS_M1_W - {{(INDEX_W-COORD_W){1'b0}}, cur_row_reg})
                : {{(INDEX_W-COORD_W){1'b0}}, cur_row_reg};

    assign led_index = base + off;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign last      = status.fin;

endmodule
